### rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

	// Default sizing of the stack
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the port fields
	localparam int FIELD_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

endpackage

`default_nettype wire

### rtl/mts_ram.sv
`default_nettype none

// Simple dual-port entry store: one write port, one read port, registered read data.
module mts_ram
	import mts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = 2 * DATA_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/min_tracking_stack.sv
`default_nettype none

// Channel   Direction  Handshake            Beat payload
// -------   ---------  -------------------  ------------------------------------------------
// in        sink       in_valid / in_stall  opcode, data_value
// out       source     out_valid/out_stall  popped_value, current_min, entry_count, status
//
// Push, peek and the unused opcode answer from the cached top entry. A pop that leaves the stack
// non-empty reads the new top entry back from the entry memory, which returns it in the cycle
// after the read is issued; the result beat is launched when it arrives, and input stalls meanwhile.
// After reset the stack is empty; the memory needs no clearing pass, since only entries
// below the count are ever read and each of those was written by a push.
// The result sits in an output register; a new input beat is taken while that register
// is empty or being drained in the same cycle, so out_stall backs up into in_stall.

module min_tracking_stack
	import mts_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [OPCODE_W-1:0]        opcode,
	input  wire logic signed [FIELD_W-1:0]  data_value,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [FIELD_W-1:0]       popped_value,
	output logic signed [FIELD_W-1:0]       current_min,
	output logic        [COUNT_W-1:0]       entry_count,
	output logic        [STATUS_W-1:0]      status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
	localparam int MW = 2 * DATA_WIDTH;

	typedef enum logic {
		S_RUN,
		S_FILL
	} fsm_t;

	// Sign-extend a stored pattern and cut it to the port field.
	function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] x);
		logic signed [EW-1:0] w;
		w = EW'($signed(x));
		return w[FIELD_W-1:0];
	endfunction

	fsm_t                   state_q;
	logic [CW-1:0]          count_q;
	// Top entry, cached beside the memory so push and peek never wait on a read
	logic [DATA_WIDTH-1:0]  top_val_q;
	logic [DATA_WIDTH-1:0]  top_min_q;
	// Output register
	logic                   out_valid_q;
	logic [FIELD_W-1:0]     popped_q;
	logic [FIELD_W-1:0]     cur_min_q;
	logic [COUNT_W-1:0]     count_out_q;
	status_t                status_q;

	logic                   out_free;
	logic                   accept;
	logic                   empty;
	logic                   full;
	logic [EW-1:0]          din_ext;
	logic [DATA_WIDTH-1:0]  push_val;
	logic [DATA_WIDTH-1:0]  push_min;
	logic [CW-1:0]          count_dec;
	logic [CW-1:0]          rd_idx;

	logic                   do_wr;
	logic                   do_rd;
	logic                   go_fill;
	logic                   res_now;
	logic [FIELD_W-1:0]     res_pop;
	logic [FIELD_W-1:0]     res_min;
	status_t                res_status;
	logic [CW-1:0]          cnt_nxt;
	logic [DATA_WIDTH-1:0]  tv_nxt;
	logic [DATA_WIDTH-1:0]  tm_nxt;
	logic [MW-1:0]          rd_data;

	// Take a beat only when not refilling the top cache and the output slot frees up.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == S_FILL) || !out_free;
	assign accept   = in_valid && !in_stall;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign din_ext   = EW'($unsigned(data_value));
	assign push_val  = din_ext[DATA_WIDTH-1:0];
	// New minimum: the value itself on an empty stack or when strictly below the top minimum.
	assign push_min  = (empty || ($signed(push_val) < $signed(top_min_q))) ? push_val : top_min_q;
	assign count_dec = count_q - CW'(1);
	// After a pop the new top sits two below the old count.
	assign rd_idx    = count_q - CW'(2);

	always_comb begin
		do_wr      = 1'b0;
		do_rd      = 1'b0;
		go_fill    = 1'b0;
		res_now    = 1'b1;
		res_pop    = '0;
		res_min    = empty ? '0 : to_field(top_min_q);
		res_status = ST_OK;
		cnt_nxt    = count_q;
		tv_nxt     = top_val_q;
		tm_nxt     = top_min_q;
		if (accept) begin
			unique case (opcode_t'(opcode))
				OP_PUSH: begin
					if (full) begin
						res_status = ST_OVER;
					end else begin
						do_wr   = 1'b1;
						cnt_nxt = count_q + CW'(1);
						tv_nxt  = push_val;
						tm_nxt  = push_min;
						res_min = to_field(push_min);
					end
				end
				OP_POP: begin
					if (empty) begin
						res_status = ST_UNDER;
					end else begin
						res_pop = to_field(top_val_q);
						cnt_nxt = count_dec;
						if (count_dec == '0) begin
							res_min = '0;
						end else begin
							// Refill the top cache from memory; the beat goes out from the fill state.
							do_rd   = 1'b1;
							go_fill = 1'b1;
							res_now = 1'b0;
						end
					end
				end
				OP_PEEK: begin
					if (empty) begin
						res_status = ST_UNDER;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The memory mirrors every pushed entry; the cache holds the top one. A write and a
	// read never land in the same cycle, so no forwarding path is needed.
	mts_ram #(
		.DEPTH (DEPTH),
		.WIDTH (MW)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({push_val, push_min}),
		.rd_en   (do_rd),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			count_q     <= '0;
			top_val_q   <= '0;
			top_min_q   <= '0;
			out_valid_q <= 1'b0;
			popped_q    <= '0;
			cur_min_q   <= '0;
			count_out_q <= '0;
			status_q    <= ST_OK;
		end else begin
			// Drop the result beat once taken; a new one below overrides this.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (accept) begin
						count_q     <= cnt_nxt;
						top_val_q   <= tv_nxt;
						top_min_q   <= tm_nxt;
						popped_q    <= res_pop;
						count_out_q <= COUNT_W'(cnt_nxt);
						status_q    <= res_status;
						if (res_now) begin
							cur_min_q   <= res_min;
							out_valid_q <= 1'b1;
						end
						if (go_fill) begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					// Output slot is empty here: it was free when the pop was taken.
					top_val_q   <= rd_data[MW-1:DATA_WIDTH];
					top_min_q   <= rd_data[DATA_WIDTH-1:0];
					cur_min_q   <= to_field(rd_data[DATA_WIDTH-1:0]);
					out_valid_q <= 1'b1;
					state_q     <= S_RUN;
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign current_min  = cur_min_q;
	assign entry_count  = count_out_q;
	assign status       = status_q;

endmodule

`default_nettype wire

### rtl/min_tracking_stack_chk.sv
`default_nettype none

module min_tracking_stack_chk
	import mts_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic [OPCODE_W-1:0]       opcode,
	input wire logic signed [FIELD_W-1:0] data_value,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic signed [FIELD_W-1:0] popped_value,
	input wire logic signed [FIELD_W-1:0] current_min,
	input wire logic [COUNT_W-1:0]        entry_count,
	input wire logic [STATUS_W-1:0]       status
);

	// Hold a stalled input beat.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(data_value))
		else $error("stalled input beat changed or dropped");

	// Hold a stalled result beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(popped_value)
			&& $stable(current_min) && $stable(entry_count) && $stable(status))
		else $error("stalled result beat changed or dropped");

	// A blocked result slot must back up into the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result slot is blocked");

	a_under_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNDER) |->
			(entry_count == '0) && (popped_value == '0) && (current_min == '0))
		else $error("underflow beat reports a non-empty stack");

	a_over_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVER) |-> (popped_value == '0))
		else $error("overflow beat carries a popped value");

endmodule

bind min_tracking_stack min_tracking_stack_chk u_chk (.*);

`default_nettype wire
